// File: rtl/vfc_pkg.sv
// Package with the shared types, codes and constant tables of the voxel face culling mesher.
`timescale 1ns / 1ps

package vfc_pkg;

   localparam int COORD_W   = 6;
   localparam int COORD_SPAN = 1 << COORD_W;
   localparam int VERT_W    = 7;
   localparam int DIM_W     = 11;
   localparam int REG_W     = 7;
   localparam int TYPE_W    = 2;
   localparam int CSR_IDX_W = 2;

   localparam int DEF_MAX_WIDTH  = 64;
   localparam int DEF_MAX_HEIGHT = 64;
   localparam int DEF_MAX_DEPTH  = 64;

   localparam logic [REG_W-1:0] DIM_RESET = 7'd64;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_DEPTH  = 2'd2;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_MESH  = 1'b1;

   localparam logic [TYPE_W-1:0] CELL_EMPTY = 2'd0;
   localparam logic [TYPE_W-1:0] CELL_SOIL  = 2'd1;
   localparam logic [TYPE_W-1:0] CELL_WATER = 2'd2;
   localparam logic [TYPE_W-1:0] CELL_OTHER = 2'd3;

   localparam logic [2:0] LAST_VERTEX = 3'd5;
   localparam logic [2:0] LAST_PROBE  = 3'd6;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic               opcode;
      logic [COORD_W-1:0] cell_x;
      logic [COORD_W-1:0] cell_y;
      logic [COORD_W-1:0] cell_z;
      logic [TYPE_W-1:0]  cell_type;
   } req_type;

   typedef struct packed {
      logic              vertex_valid;
      logic [VERT_W-1:0] vert_x;
      logic [VERT_W-1:0] vert_y;
      logic [VERT_W-1:0] vert_z;
      logic              tex_u;
      logic              tex_v;
      logic [2:0]        face_index;
      logic              segment;
      logic [5:0]        visible_mask;
      logic [2:0]        visible_count;
      logic              last;
   } rsp_type;

   // Cube corners: bit 2 is the x offset, bit 1 the y offset, bit 0 the z offset.
   localparam logic [2:0] CORNER_BITS [8] = '{3'd1, 3'd5, 3'd7, 3'd3, 3'd0, 3'd4, 3'd6, 3'd2};

   localparam logic [2:0] FACE_CORNERS [36] = '{
      3'd1, 3'd5, 3'd6, 3'd1, 3'd6, 3'd2,
      3'd4, 3'd0, 3'd3, 3'd4, 3'd3, 3'd7,
      3'd3, 3'd2, 3'd6, 3'd3, 3'd6, 3'd7,
      3'd4, 3'd5, 3'd1, 3'd4, 3'd1, 3'd0,
      3'd0, 3'd1, 3'd2, 3'd0, 3'd2, 3'd3,
      3'd5, 3'd4, 3'd7, 3'd5, 3'd7, 3'd6
   };

   localparam logic QUAD_U [6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
   localparam logic QUAD_V [6] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

   function automatic logic [2:0] corner_of(input logic [2:0] face, input logic [2:0] vtx);
      logic [5:0] idx;
      idx = 6'(face) * 6'd6 + 6'(vtx);
      return CORNER_BITS[FACE_CORNERS[idx]];
   endfunction

endpackage

// File: rtl/voxel_face_cull_mesher_core.sv
// Top level of the voxel face culling mesher: voxel store, neighbor probe sequencer, vertex emitter.
//
//   channel   direction   handshake            payload
//   req_      in          req_valid/req_stall  vfc_pkg::req_type
//   rsp_      out         rsp_valid/rsp_stall  vfc_pkg::rsp_type
//   csr_      in          csr_valid/csr_ready  csr_index, csr_wdata
//
// A write request goes to the store as it is accepted. A mesh request is accepted, then the cell
// and its six neighbors are read through the single store port, the last read data is taken in,
// hidden faces ahead of the last visible one (up to five) are skipped, and the results (up to
// 36) follow one per cycle while the output register is free and no hidden face is skipped.
// After reset the store is cleared one cell per cycle, all 2**(address bits) cells (262144 at
// the default sizes); requests are stalled meanwhile, register writes are always taken.
// A stalled result holds the emitter until it is taken.
`timescale 1ns / 1ps

module voxel_face_cull_mesher_core #(
   parameter int MAX_WIDTH  = vfc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = vfc_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_DEPTH  = vfc_pkg::DEF_MAX_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  vfc_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output vfc_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [vfc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [vfc_pkg::REG_W-1:0]      csr_wdata
);

   localparam int XN     = (MAX_WIDTH < vfc_pkg::COORD_SPAN) ? MAX_WIDTH : vfc_pkg::COORD_SPAN;
   localparam int YN     = (MAX_HEIGHT < vfc_pkg::COORD_SPAN) ? MAX_HEIGHT : vfc_pkg::COORD_SPAN;
   localparam int ZN     = (MAX_DEPTH < vfc_pkg::COORD_SPAN) ? MAX_DEPTH : vfc_pkg::COORD_SPAN;
   localparam int XW     = $clog2(XN);
   localparam int YW     = $clog2(YN);
   localparam int ZW     = $clog2(ZN);
   localparam int ADDR_W = XW + YW + ZW;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int DW     = vfc_pkg::DIM_W;
   localparam int CW     = vfc_pkg::COORD_W;

   localparam logic [DW-1:0] MAX_X = DW'(MAX_WIDTH);
   localparam logic [DW-1:0] MAX_Y = DW'(MAX_HEIGHT);
   localparam logic [DW-1:0] MAX_Z = DW'(MAX_DEPTH);

   vfc_pkg::state_type             state_ff, state_in;
   logic [ADDR_W-1:0]              clear_addr_ff, clear_addr_in;
   vfc_pkg::req_type               req_ff, req_in;
   logic [2:0]                     probe_ff, probe_in;
   logic                           pend_ff, pend_in;
   logic [2:0]                     pend_idx_ff, pend_idx_in;
   logic                           pend_ok_ff, pend_ok_in;
   logic [vfc_pkg::TYPE_W-1:0]     self_ff, self_in;
   logic [5:0]                     mask_ff, mask_in;
   logic [2:0]                     count_ff, count_in;
   logic [2:0]                     face_ff, face_in;
   logic [2:0]                     vtx_ff, vtx_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   vfc_pkg::rsp_type               rsp_data_ff, rsp_data_in;
   logic [vfc_pkg::REG_W-1:0]      width_ff, width_in;
   logic [vfc_pkg::REG_W-1:0]      height_ff, height_in;
   logic [vfc_pkg::REG_W-1:0]      depth_ff, depth_in;

   logic                           ram_we;
   logic [ADDR_W-1:0]              ram_addr;
   logic [vfc_pkg::TYPE_W-1:0]     ram_wdata;
   logic [vfc_pkg::TYPE_W-1:0]     ram_rdata;

   logic [DW-1:0]                  w_eff, h_eff, d_eff;
   logic                           self_inside, wr_inside;
   logic [CW-1:0]                  nb_x, nb_y, nb_z;
   logic                           nb_ok;
   logic [ADDR_W-1:0]              probe_addr, wr_addr;
   logic [2:0]                     corner;
   logic [5:0]                     upper_mask;
   logic                           face_last;
   logic                           out_free;

   vfc_ram #(
      .WIDTH (vfc_pkg::TYPE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign w_eff = (width_ff == '0) ? DW'(1) :
                  ((DW'(width_ff) > MAX_X) ? MAX_X : DW'(width_ff));
   assign h_eff = (height_ff == '0) ? DW'(1) :
                  ((DW'(height_ff) > MAX_Y) ? MAX_Y : DW'(height_ff));
   assign d_eff = (depth_ff == '0) ? DW'(1) :
                  ((DW'(depth_ff) > MAX_Z) ? MAX_Z : DW'(depth_ff));

   assign self_inside = (DW'(req_ff.cell_x) < w_eff) && (DW'(req_ff.cell_y) < h_eff) &&
                        (DW'(req_ff.cell_z) < d_eff);
   assign wr_inside   = (DW'(req_data.cell_x) < w_eff) && (DW'(req_data.cell_y) < h_eff) &&
                        (DW'(req_data.cell_z) < d_eff);

   always_comb begin
      nb_x  = req_ff.cell_x;
      nb_y  = req_ff.cell_y;
      nb_z  = req_ff.cell_z;
      nb_ok = 1'b1;
      case (probe_ff)
         3'd1: begin
            nb_x  = req_ff.cell_x + CW'(1);
            nb_ok = (DW'(req_ff.cell_x) + DW'(1)) < w_eff;
         end
         3'd2: begin
            nb_x  = req_ff.cell_x - CW'(1);
            nb_ok = req_ff.cell_x != '0;
         end
         3'd3: begin
            nb_y  = req_ff.cell_y + CW'(1);
            nb_ok = (DW'(req_ff.cell_y) + DW'(1)) < h_eff;
         end
         3'd4: begin
            nb_y  = req_ff.cell_y - CW'(1);
            nb_ok = req_ff.cell_y != '0;
         end
         3'd5: begin
            nb_z  = req_ff.cell_z + CW'(1);
            nb_ok = (DW'(req_ff.cell_z) + DW'(1)) < d_eff;
         end
         3'd6: begin
            nb_z  = req_ff.cell_z - CW'(1);
            nb_ok = req_ff.cell_z != '0;
         end
         default: begin
            nb_ok = 1'b1;
         end
      endcase
   end

   assign probe_addr = {nb_z[ZW-1:0], nb_y[YW-1:0], nb_x[XW-1:0]};
   assign wr_addr    = {req_data.cell_z[ZW-1:0], req_data.cell_y[YW-1:0],
                        req_data.cell_x[XW-1:0]};

   assign corner     = vfc_pkg::corner_of(face_ff, vtx_ff);
   assign upper_mask = mask_ff >> face_ff;
   assign face_last  = (upper_mask[5:1] == '0);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      req_in        = req_ff;
      probe_in      = probe_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      pend_ok_in    = pend_ok_ff;
      self_in       = self_ff;
      mask_in       = mask_ff;
      count_in      = count_ff;
      face_in       = face_ff;
      vtx_in        = vtx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      depth_in      = depth_ff;
      ram_we        = 1'b0;
      ram_addr      = probe_addr;
      ram_wdata     = req_data.cell_type;
      req_stall     = 1'b1;

      if (csr_valid) begin
         case (csr_index)
            vfc_pkg::CSR_GRID_WIDTH:  width_in  = csr_wdata;
            vfc_pkg::CSR_GRID_HEIGHT: height_in = csr_wdata;
            vfc_pkg::CSR_GRID_DEPTH:  depth_in  = csr_wdata;
            default: begin
            end
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Read data of the probe issued in the previous cycle.
      if (pend_ff) begin
         if (pend_idx_ff == '0) begin
            self_in = self_inside ? ram_rdata : vfc_pkg::CELL_EMPTY;
         end else if (pend_ok_ff &&
                      (self_ff == vfc_pkg::CELL_SOIL || self_ff == vfc_pkg::CELL_WATER) &&
                      (ram_rdata == vfc_pkg::CELL_EMPTY ||
                       (ram_rdata == vfc_pkg::CELL_WATER && self_ff == vfc_pkg::CELL_SOIL))) begin
            mask_in[pend_idx_ff - 3'd1] = 1'b1;
            count_in = count_ff + 3'd1;
         end
      end

      case (state_ff)
         vfc_pkg::ST_CLEAR: begin
            ram_we        = 1'b1;
            ram_addr      = clear_addr_ff;
            ram_wdata     = vfc_pkg::CELL_EMPTY;
            clear_addr_in = clear_addr_ff + ADDR_W'(1);
            if (clear_addr_ff == '1) begin
               state_in = vfc_pkg::ST_IDLE;
            end
         end
         vfc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               req_in = req_data;
               if (req_data.opcode == vfc_pkg::OP_WRITE) begin
                  ram_we   = wr_inside;
                  ram_addr = wr_addr;
               end else begin
                  mask_in  = '0;
                  count_in = '0;
                  probe_in = '0;
                  self_in  = vfc_pkg::CELL_EMPTY;
                  state_in = vfc_pkg::ST_PROBE;
               end
            end
         end
         vfc_pkg::ST_PROBE: begin
            if (probe_ff <= vfc_pkg::LAST_PROBE) begin
               pend_in     = 1'b1;
               pend_idx_in = probe_ff;
               pend_ok_in  = nb_ok;
               probe_in    = probe_ff + 3'd1;
            end else begin
               face_in  = '0;
               vtx_in   = '0;
               state_in = vfc_pkg::ST_EMIT;
            end
         end
         vfc_pkg::ST_EMIT: begin
            if (count_ff == '0) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  rsp_data_in.segment = (self_ff == vfc_pkg::CELL_WATER);
                  rsp_data_in.last    = 1'b1;
                  state_in = vfc_pkg::ST_IDLE;
               end
            end else if (!mask_ff[face_ff]) begin
               face_in = face_ff + 3'd1;
            end else if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.vertex_valid   = 1'b1;
               rsp_data_in.vert_x         = {1'b0, req_ff.cell_x} + 7'(corner[2]);
               rsp_data_in.vert_y         = {1'b0, req_ff.cell_y} + 7'(corner[1]);
               rsp_data_in.vert_z         = {1'b0, req_ff.cell_z} + 7'(corner[0]);
               rsp_data_in.tex_u          = vfc_pkg::QUAD_U[vtx_ff];
               rsp_data_in.tex_v          = vfc_pkg::QUAD_V[vtx_ff];
               rsp_data_in.face_index     = face_ff;
               rsp_data_in.segment        = (self_ff == vfc_pkg::CELL_WATER);
               rsp_data_in.visible_mask   = mask_ff;
               rsp_data_in.visible_count  = count_ff;
               rsp_data_in.last           = (vtx_ff == vfc_pkg::LAST_VERTEX) && face_last;
               if (vtx_ff == vfc_pkg::LAST_VERTEX) begin
                  vtx_in  = '0;
                  face_in = face_ff + 3'd1;
                  if (face_last) begin
                     state_in = vfc_pkg::ST_IDLE;
                  end
               end else begin
                  vtx_in = vtx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = vfc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= vfc_pkg::ST_CLEAR;
         clear_addr_ff <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         width_ff      <= vfc_pkg::DIM_RESET;
         height_ff     <= vfc_pkg::DIM_RESET;
         depth_ff      <= vfc_pkg::DIM_RESET;
         probe_ff      <= '0;
         face_ff       <= '0;
         vtx_ff        <= '0;
         mask_ff       <= '0;
         count_ff      <= '0;
         self_ff       <= vfc_pkg::CELL_EMPTY;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         depth_ff      <= depth_in;
         probe_ff      <= probe_in;
         face_ff       <= face_in;
         vtx_ff        <= vtx_in;
         mask_ff       <= mask_in;
         count_ff      <= count_in;
         self_ff       <= self_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      pend_idx_ff <= pend_idx_in;
      pend_ok_ff  <= pend_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // A write request never produces a result.
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.opcode == vfc_pkg::OP_WRITE && !rsp_valid)
      |=> !rsp_valid)
      else $error("result appeared after a write request");

   // A result without a vertex is always the final one of its request.
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.vertex_valid) |-> rsp_data.last)
      else $error("empty result not marked last");

   // The face count agrees with the visible face mask.
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.vertex_valid) |->
      (32'(rsp_data.visible_count) == $countones(rsp_data.visible_mask)))
      else $error("visible count does not match mask");

   // No results while the store is being cleared.
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vfc_pkg::ST_CLEAR) |-> (!rsp_valid && req_stall))
      else $error("activity during store clearing");

endmodule

// File: rtl/vfc_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module vfc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 262144
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule
